// ----- rtl/core/dpmm_pkg.sv -----
// ----------------------------------------------------------------------------
// dpmm_pkg
// Shared sizes, request and status codes and control types of the demand
// paged memory manager.
// ----------------------------------------------------------------------------
package dpmm_pkg;

	// sizing
	localparam int MAX_PROCS   = 8;
	localparam int MAX_PAGES   = 16;
	localparam int FRAME_BYTES = 16;
	localparam int MAX_FRAMES  = 16;

	localparam int PROC_W  = 3;
	localparam int PAGE_W  = 4;
	localparam int OFS_W   = 4;
	localparam int FRAME_W = 4;
	localparam int SLOT_W  = PROC_W + PAGE_W;
	localparam int CNT_W   = 5;

	localparam int NUM_SLOTS = MAX_PROCS * MAX_PAGES;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;
	localparam logic [OFS_W-1:0] OFS_LAST     = 4'(FRAME_BYTES - 1);

	// request codes
	localparam logic [2:0] REQ_ALLOC = 3'd0;
	localparam logic [2:0] REQ_FREE  = 3'd1;
	localparam logic [2:0] REQ_READ  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_FRAME = 3'd1;
	localparam logic [2:0] ST_NO_VICT  = 3'd2;
	localparam logic [2:0] ST_BAD_OFS  = 3'd3;
	localparam logic [2:0] ST_PAGE_OOR = 3'd4;

	// free stack control
	typedef struct packed {
		logic                 init;
		logic [CNT_W-1:0]     init_count;
		logic                 push;
		logic [FRAME_W-1:0]   push_frame;
		logic                 pop;
	} stk_ctl_t;

endpackage

// ----- rtl/core/dpmm_req_if.sv -----
// ----------------------------------------------------------------------------
// dpmm_req_if
// Request channel: valid/ready handshake with the request item.
// ----------------------------------------------------------------------------
interface dpmm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [2:0]  pid;
	logic [7:0]  vaddr;
	logic [8:0]  request_bytes;
	logic [15:0] write_data;

	modport source (output valid, req_type, pid, vaddr, request_bytes, write_data,
		input ready);
	modport sink (input valid, req_type, pid, vaddr, request_bytes, write_data,
		output ready);
endinterface

// ----- rtl/core/dpmm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dpmm_rsp_if
// Result channel: valid/ready handshake with the result item.
// ----------------------------------------------------------------------------
interface dpmm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] read_data;
	logic [7:0]  phys_addr;
	logic        page_fault;
	logic [3:0]  evicted_pages;
	logic [4:0]  free_frames;
	logic [4:0]  process_pages;
	logic        addr_valid;
	logic [31:0] paged_in_total;
	logic [31:0] paged_out_total;

	modport source (output valid, status, read_data, phys_addr, page_fault,
		evicted_pages, free_frames, process_pages, addr_valid, paged_in_total,
		paged_out_total, input ready);
	modport sink (input valid, status, read_data, phys_addr, page_fault,
		evicted_pages, free_frames, process_pages, addr_valid, paged_in_total,
		paged_out_total, output ready);
endinterface

// ----- rtl/core/demand_paged_memory_manager.sv -----
// ----------------------------------------------------------------------------
// demand_paged_memory_manager
// Per-process page tables over a shared free-frame stack, with byte-serial
// frame zeroing, page-out and page-in against a backing store.
// ----------------------------------------------------------------------------
// Work per item: free walks all pages; allocate zeroes each new frame byte by
// byte; a fault pages in, and on an empty stack first scans the processes and
// evicts the first valid page of each present process (max 8).
// One item at a time; a new request is taken only once the result is loaded.
// Reset: async, active low; tables empty, all frames free, counters zero.
// Backing store reads as zero per slot until first written (per-slot flags).
module demand_paged_memory_manager (
	input  logic                clk,
	input  logic                arst_n,
	dpmm_req_if.sink            req,
	dpmm_rsp_if.source          rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int FW = dpmm_pkg::FRAME_W;
	localparam int OW = dpmm_pkg::OFS_W;
	localparam int SW = dpmm_pkg::SLOT_W;
	localparam int CW = dpmm_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_AL_PAGE, S_ZERO, S_FR_RD, S_FR_PUSH, S_EV_SCAN, S_EV_RDF,
		S_EV_COPY, S_PI_POP, S_PI_COPY, S_AC_FR, S_AC_GET, S_AC_B0, S_AC_B1,
		S_AC_B2, S_DONE
	} state_t;

	state_t state_q;

	// request and work registers
	logic [2:0]        rt_q;
	logic [2:0]        pid_q;
	logic [7:0]        vaddr_q;
	logic [15:0]       wd_q;
	logic [CW-1:0]     need_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     cnt_q;
	logic [SW-1:0]     e_q;
	logic [SW-1:0]     ev_slot_q;
	logic [FW-1:0]     f_q;
	logic [2:0]        status_q;
	logic [15:0]       rd_q;
	logic [7:0]        pa_q;
	logic              pf_q;
	logic [3:0]        ev_q;
	logic [31:0]       in_cnt_q;
	logic [31:0]       out_cnt_q;
	logic [CW-1:0]     active_q;

	logic [dpmm_pkg::MAX_PROCS-1:0] present_q;
	logic [dpmm_pkg::NUM_SLOTS-1:0] valid_q;
	logic [dpmm_pkg::NUM_SLOTS-1:0] slot_ok_q;

	// result register
	logic        ov_q;
	logic [2:0]  o_status_q;
	logic [15:0] o_rd_q;
	logic [7:0]  o_pa_q;
	logic        o_pf_q;
	logic [3:0]  o_ev_q;
	logic [4:0]  o_free_q;
	logic [4:0]  o_pages_q;
	logic        o_av_q;
	logic [31:0] o_in_q;
	logic [31:0] o_out_q;

	// memories
	logic [FW-1:0] pf_mem [dpmm_pkg::NUM_SLOTS];
	logic [7:0]    fb_mem [dpmm_pkg::MAX_FRAMES * dpmm_pkg::FRAME_BYTES];
	logic [7:0]    bk_mem [dpmm_pkg::NUM_SLOTS * dpmm_pkg::FRAME_BYTES];
	logic [FW-1:0] pf_rdata_q;
	logic [7:0]    fb_rdata_q;
	logic [7:0]    bk_rdata_q;

	logic              pf_we;
	logic [SW-1:0]     pf_waddr, pf_raddr;
	logic [FW-1:0]     pf_wdata;
	logic              fb_we;
	logic [FW+OW-1:0]  fb_waddr, fb_raddr;
	logic [7:0]        fb_wdata;
	logic              bk_we;
	logic [SW+OW-1:0]  bk_waddr, bk_raddr;

	dpmm_pkg::stk_ctl_t stk;
	logic [FW-1:0]      top_frame;
	logic [CW-1:0]      fc;

	logic              acc, cfg_wr;
	logic [CW-1:0]     cfg_val;
	logic [OW-1:0]     off, off1, cnt_lo, cnt_wr;
	logic [15:0]       pv;
	logic [3:0]        fv;
	logic              pv_any;
	logic [4:0]        pages;
	logic [15:0]       own;

	dpmm_free_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk),
		.top_frame (top_frame),
		.count     (fc)
	);

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && !paddr[2];
	assign prdata    = {27'd0, active_q};

	assign off    = vaddr_q[OW-1:0];
	assign off1   = off + 4'd1;
	assign cnt_lo = cnt_q[OW-1:0];
	assign cnt_wr = OW'(cnt_q - 5'd1);

	// saturate the written frame count to 1..MAX_FRAMES
	always_comb begin
		cfg_val = pwdata[CW-1:0];
		if (cfg_val == '0)
			cfg_val = 5'd1;
		else if (cfg_val > CW'(dpmm_pkg::MAX_FRAMES))
			cfg_val = CW'(dpmm_pkg::MAX_FRAMES);
	end

	// first valid page of the process under scan
	always_comb begin
		for (int v = 0; v < 16; v++)
			pv[v] = valid_q[{i_q[2:0], 4'(v)}];
		pv_any = |pv;
		fv = '0;
		for (int v = 15; v >= 0; v--)
			if (pv[v])
				fv = 4'(v);
	end

	// valid page count of the requesting process
	always_comb begin
		pages = '0;
		for (int v = 0; v < 16; v++) begin
			own[v] = valid_q[{pid_q, 4'(v)}];
			pages  = pages + 5'(own[v]);
		end
	end

	// memory ports and stack control per state
	always_comb begin
		stk      = '0;
		pf_we    = 1'b0;
		pf_waddr = e_q;
		pf_wdata = top_frame;
		pf_raddr = e_q;
		fb_we    = 1'b0;
		fb_waddr = {f_q, cnt_wr};
		fb_wdata = '0;
		fb_raddr = {f_q, cnt_lo};
		bk_we    = 1'b0;
		bk_waddr = {ev_slot_q, cnt_wr};
		bk_raddr = {e_q, cnt_lo};
		case (state_q)
			S_AL_PAGE: begin
				if (i_q != need_q && !i_q[4] && fc != '0) begin
					stk.pop  = 1'b1;
					pf_we    = 1'b1;
					pf_waddr = {pid_q, i_q[3:0]};
				end
			end
			S_ZERO: begin
				fb_we    = 1'b1;
				fb_waddr = {f_q, cnt_lo};
			end
			S_FR_RD: pf_raddr = {pid_q, i_q[3:0]};
			S_FR_PUSH: begin
				if (valid_q[{pid_q, i_q[3:0]}]) begin
					stk.push       = 1'b1;
					stk.push_frame = pf_rdata_q;
				end
			end
			S_EV_SCAN: pf_raddr = {i_q[2:0], fv};
			S_EV_COPY: begin
				bk_we = (cnt_q != '0);
				if (cnt_q[4]) begin
					stk.push       = 1'b1;
					stk.push_frame = f_q;
				end
			end
			S_PI_POP: stk.pop = (fc != '0);
			S_PI_COPY: begin
				fb_we    = (cnt_q != '0);
				fb_wdata = slot_ok_q[e_q] ? bk_rdata_q : 8'd0;
				if (cnt_q[4]) begin
					pf_we    = 1'b1;
					pf_wdata = f_q;
				end
			end
			S_AC_B0: begin
				fb_raddr = {f_q, off};
				fb_waddr = {f_q, off};
				fb_wdata = wd_q[15:8];
				fb_we    = (rt_q == dpmm_pkg::REQ_WRITE);
			end
			S_AC_B1: begin
				fb_raddr = {f_q, off1};
				fb_waddr = {f_q, off1};
				fb_wdata = wd_q[7:0];
				fb_we    = (rt_q == dpmm_pkg::REQ_WRITE);
			end
			default: ;
		endcase
		if (cfg_wr) begin
			stk.init       = 1'b1;
			stk.init_count = cfg_val;
		end
	end

	// page-frame table
	always_ff @(posedge clk) begin
		if (pf_we)
			pf_mem[pf_waddr] <= pf_wdata;
		pf_rdata_q <= pf_mem[pf_raddr];
	end

	// physical frame bytes
	always_ff @(posedge clk) begin
		if (fb_we)
			fb_mem[fb_waddr] <= fb_wdata;
		fb_rdata_q <= fb_mem[fb_raddr];
	end

	// backing store
	always_ff @(posedge clk) begin
		if (bk_we)
			bk_mem[bk_waddr] <= fb_rdata_q;
		bk_rdata_q <= bk_mem[bk_raddr];
	end

	// sequencer, tables and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			present_q <= '0;
			valid_q   <= '0;
			slot_ok_q <= '0;
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			active_q  <= dpmm_pkg::ACTIVE_RESET;
			ov_q      <= 1'b0;
		end else begin
			// result slot: load on a finished item, free once taken
			if (state_q == S_DONE && (!ov_q || rsp.ready))
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			if (cfg_wr) begin
				active_q  <= cfg_val;
				present_q <= '0;
				valid_q   <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						rt_q     <= req.req_type;
						pid_q    <= req.pid;
						vaddr_q  <= req.vaddr;
						wd_q     <= req.write_data;
						need_q   <= req.request_bytes[8:4];
						e_q      <= {req.pid, req.vaddr[7:4]};
						i_q      <= '0;
						cnt_q    <= '0;
						status_q <= dpmm_pkg::ST_OK;
						rd_q     <= '0;
						pa_q     <= '0;
						pf_q     <= 1'b0;
						ev_q     <= '0;
						case (req.req_type)
							dpmm_pkg::REQ_ALLOC: begin
								for (int v = 0; v < 16; v++)
									valid_q[{req.pid, 4'(v)}] <= 1'b0;
								present_q[req.pid] <= 1'b1;
								state_q <= S_AL_PAGE;
							end
							dpmm_pkg::REQ_FREE: begin
								state_q <= present_q[req.pid] ? S_FR_RD : S_DONE;
							end
							dpmm_pkg::REQ_READ, dpmm_pkg::REQ_WRITE: begin
								if (req.vaddr[OW-1:0] == dpmm_pkg::OFS_LAST) begin
									status_q <= dpmm_pkg::ST_BAD_OFS;
									state_q  <= S_DONE;
								end else begin
									present_q[req.pid] <= 1'b1;
									if (valid_q[{req.pid, req.vaddr[7:4]}]) begin
										state_q <= S_AC_FR;
									end else begin
										pf_q    <= 1'b1;
										state_q <= (fc == '0) ? S_EV_SCAN : S_PI_POP;
									end
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				// allocate: one page per pass, then zero its frame
				S_AL_PAGE: begin
					if (i_q == need_q) begin
						state_q <= S_DONE;
					end else if (i_q[4]) begin
						status_q <= dpmm_pkg::ST_PAGE_OOR;
						state_q  <= S_DONE;
					end else if (fc == '0) begin
						status_q <= dpmm_pkg::ST_NO_FRAME;
						state_q  <= S_DONE;
					end else begin
						valid_q[{pid_q, i_q[3:0]}] <= 1'b1;
						f_q     <= top_frame;
						cnt_q   <= '0;
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_lo == OW'(dpmm_pkg::FRAME_BYTES - 1)) begin
						i_q     <= i_q + 5'd1;
						state_q <= S_AL_PAGE;
					end
				end
				// free: walk pages in order, pushing valid frames
				S_FR_RD: state_q <= S_FR_PUSH;
				S_FR_PUSH: begin
					valid_q[{pid_q, i_q[3:0]}] <= 1'b0;
					if (i_q[3:0] == 4'(dpmm_pkg::MAX_PAGES - 1)) begin
						present_q[pid_q] <= 1'b0;
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 5'd1;
						state_q <= S_FR_RD;
					end
				end
				// eviction: first valid page of each present process
				S_EV_SCAN: begin
					if (present_q[i_q[2:0]] && pv_any) begin
						ev_slot_q <= {i_q[2:0], fv};
						state_q   <= S_EV_RDF;
					end else if (i_q[2:0] == 3'(dpmm_pkg::MAX_PROCS - 1)) begin
						state_q <= S_PI_POP;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				S_EV_RDF: begin
					f_q     <= pf_rdata_q;
					cnt_q   <= '0;
					state_q <= S_EV_COPY;
				end
				S_EV_COPY: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[4]) begin
						slot_ok_q[ev_slot_q] <= 1'b1;
						valid_q[ev_slot_q]   <= 1'b0;
						out_cnt_q <= out_cnt_q + 32'd1;
						ev_q      <= ev_q + 4'd1;
						if (i_q[2:0] == 3'(dpmm_pkg::MAX_PROCS - 1)) begin
							state_q <= S_PI_POP;
						end else begin
							i_q     <= i_q + 5'd1;
							state_q <= S_EV_SCAN;
						end
					end
				end
				// page-in from the backing slot
				S_PI_POP: begin
					if (fc == '0) begin
						status_q <= dpmm_pkg::ST_NO_VICT;
						state_q  <= S_DONE;
					end else begin
						f_q     <= top_frame;
						cnt_q   <= '0;
						state_q <= S_PI_COPY;
					end
				end
				S_PI_COPY: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[4]) begin
						in_cnt_q     <= in_cnt_q + 32'd1;
						valid_q[e_q] <= 1'b1;
						state_q      <= S_AC_B0;
					end
				end
				// word access, big-endian
				S_AC_FR: state_q <= S_AC_GET;
				S_AC_GET: begin
					f_q     <= pf_rdata_q;
					state_q <= S_AC_B0;
				end
				S_AC_B0: begin
					pa_q    <= {f_q, off};
					state_q <= S_AC_B1;
				end
				S_AC_B1: begin
					if (rt_q == dpmm_pkg::REQ_WRITE) begin
						state_q <= S_DONE;
					end else begin
						rd_q[15:8] <= fb_rdata_q;
						state_q    <= S_AC_B2;
					end
				end
				S_AC_B2: begin
					rd_q[7:0] <= fb_rdata_q;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						o_status_q <= status_q;
						o_rd_q     <= rd_q;
						o_pa_q     <= pa_q;
						o_pf_q     <= pf_q;
						o_ev_q     <= ev_q;
						o_free_q   <= fc;
						o_pages_q  <= pages;
						o_av_q     <= valid_q[e_q];
						o_in_q     <= in_cnt_q;
						o_out_q    <= out_cnt_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.status          = o_status_q;
	assign rsp.read_data       = o_rd_q;
	assign rsp.phys_addr       = o_pa_q;
	assign rsp.page_fault      = o_pf_q;
	assign rsp.evicted_pages   = o_ev_q;
	assign rsp.free_frames     = o_free_q;
	assign rsp.process_pages   = o_pages_q;
	assign rsp.addr_valid      = o_av_q;
	assign rsp.paged_in_total  = o_in_q;
	assign rsp.paged_out_total = o_out_q;

	// checks
	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fc <= CW'(dpmm_pkg::MAX_FRAMES))
		else $error("free stack deeper than frame count");

	a_evict_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.page_fault |-> rsp.evicted_pages == 4'd0)
		else $error("eviction without a page fault");

	a_bad_ofs_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == dpmm_pkg::ST_BAD_OFS |->
		rsp.phys_addr == 8'd0 && rsp.read_data == 16'd0)
		else $error("bad offset item carries access data");

endmodule

// ----- rtl/core/dpmm_free_stack.sv -----
// ----------------------------------------------------------------------------
// dpmm_free_stack
// LIFO of free frame numbers with a depth counter; refilled 0 upward on init.
// ----------------------------------------------------------------------------
module dpmm_free_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dpmm_pkg::stk_ctl_t             ctl,
	output logic [dpmm_pkg::FRAME_W-1:0]   top_frame,
	output logic [dpmm_pkg::CNT_W-1:0]     count
);

	logic [dpmm_pkg::FRAME_W-1:0] stack_q [dpmm_pkg::MAX_FRAMES];
	logic [dpmm_pkg::CNT_W-1:0]   count_q;

	assign count     = count_q;
	assign top_frame = stack_q[dpmm_pkg::FRAME_W'(count_q - 5'd1)];

	// init, push (drops when full), pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dpmm_pkg::MAX_FRAMES; i++)
				stack_q[i] <= dpmm_pkg::FRAME_W'(i);
			count_q <= dpmm_pkg::ACTIVE_RESET;
		end else if (ctl.init) begin
			for (int i = 0; i < dpmm_pkg::MAX_FRAMES; i++)
				stack_q[i] <= dpmm_pkg::FRAME_W'(i);
			count_q <= ctl.init_count;
		end else if (ctl.push) begin
			if (count_q < dpmm_pkg::CNT_W'(dpmm_pkg::MAX_FRAMES)) begin
				stack_q[dpmm_pkg::FRAME_W'(count_q)] <= ctl.push_frame;
				count_q <= count_q + 5'd1;
			end
		end else if (ctl.pop) begin
			count_q <= count_q - 5'd1;
		end
	end

endmodule
